// ===== sv/lcp_pkg.sv =====
// Shared types and constants of the parametric line clipper.
// Used by every module of the block; depends on nothing.
package lcp_pkg;

   localparam int CW        = 16;
   localparam int FW        = 16;
   localparam int QW        = FW + 2;
   localparam int TW        = QW + 1;
   localparam int DIV_STEPS = QW;
   localparam int LANES     = 4;
   localparam int NCOORD    = 4;

   typedef logic signed [CW-1:0] coord_type;
   typedef logic signed [CW:0]   diff_type;
   typedef logic [CW-1:0]        mag_type;
   typedef logic [QW-1:0]        quo_type;
   typedef logic signed [TW-1:0] ratio_type;
   typedef logic [FW:0]          param_type;

   typedef enum logic [1:0] {
      REG_WIN_LEFT   = 2'd0,
      REG_WIN_BOTTOM = 2'd1,
      REG_WIN_RIGHT  = 2'd2,
      REG_WIN_TOP    = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic pzero;
      logic qneg;
      logic pneg;
      logic neg;
   } lane_tag_type;

   typedef struct packed {
      coord_type x0;
      coord_type y0;
      diff_type  dx;
      diff_type  dy;
   } seg_type;

   localparam ratio_type T_ONE = TW'(1) << FW;
   localparam quo_type   Q_SAT = QW'(2) << FW;

endpackage

// ===== sv/lcp_setup.sv =====
// Entry stage: differences, boundary distances and divider operands.
// Depends on lcp_pkg.
module lcp_setup (
   input  logic                                clock,
   input  logic                                en,
   input  lcp_pkg::coord_type                  start_x,
   input  lcp_pkg::coord_type                  start_y,
   input  lcp_pkg::coord_type                  end_x,
   input  lcp_pkg::coord_type                  end_y,
   input  lcp_pkg::coord_type                  win_left,
   input  lcp_pkg::coord_type                  win_bottom,
   input  lcp_pkg::coord_type                  win_right,
   input  lcp_pkg::coord_type                  win_top,
   output lcp_pkg::mag_type                    aq [lcp_pkg::LANES],
   output lcp_pkg::mag_type                    ap [lcp_pkg::LANES],
   output logic                                sat [lcp_pkg::LANES],
   output lcp_pkg::lane_tag_type               tag [lcp_pkg::LANES],
   output lcp_pkg::seg_type                    seg
);
   import lcp_pkg::*;

   diff_type     p [LANES];
   diff_type     q [LANES];
   diff_type     dx, dy;
   mag_type      aq_ff [LANES], aq_in [LANES];
   mag_type      ap_ff [LANES], ap_in [LANES];
   logic         sat_ff [LANES], sat_in [LANES];
   lane_tag_type tag_ff [LANES], tag_in [LANES];
   seg_type      seg_ff, seg_in;

   always_comb begin
      dx   = diff_type'(end_x) - diff_type'(start_x);
      dy   = diff_type'(end_y) - diff_type'(start_y);
      p[0] = -dx;
      q[0] = diff_type'(start_x) - diff_type'(win_left);
      p[1] = dx;
      q[1] = diff_type'(win_right) - diff_type'(start_x);
      p[2] = -dy;
      q[2] = diff_type'(start_y) - diff_type'(win_bottom);
      p[3] = dy;
      q[3] = diff_type'(win_top) - diff_type'(start_y);
      for (int i = 0; i < LANES; i++) begin
         ap_in[i]        = p[i][CW] ? mag_type'(-p[i]) : mag_type'(p[i]);
         aq_in[i]        = q[i][CW] ? mag_type'(-q[i]) : mag_type'(q[i]);
         sat_in[i]       = {1'b0, aq_in[i]} > {ap_in[i], 1'b0};
         tag_in[i].pzero = (p[i] == '0);
         tag_in[i].qneg  = q[i][CW];
         tag_in[i].pneg  = p[i][CW];
         tag_in[i].neg   = q[i][CW] ^ p[i][CW];
      end
      seg_in.x0 = start_x;
      seg_in.y0 = start_y;
      seg_in.dx = dx;
      seg_in.dy = dy;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         aq_ff  <= aq_in;
         ap_ff  <= ap_in;
         sat_ff <= sat_in;
         tag_ff <= tag_in;
         seg_ff <= seg_in;
      end
   end

   assign aq  = aq_ff;
   assign ap  = ap_ff;
   assign sat = sat_ff;
   assign tag = tag_ff;
   assign seg = seg_ff;

endmodule

// ===== sv/lcp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, for one boundary.
// Depends on lcp_pkg.
module lcp_div (
   input  logic                  clock,
   input  logic                  en,
   input  lcp_pkg::mag_type      aq,
   input  lcp_pkg::mag_type      ap,
   input  logic                  sat,
   input  lcp_pkg::lane_tag_type tag,
   output lcp_pkg::quo_type      quo,
   output lcp_pkg::lane_tag_type tag_out
);
   import lcp_pkg::*;

   mag_type      rem_ff [DIV_STEPS], rem_in [DIV_STEPS];
   quo_type      quo_ff [DIV_STEPS], quo_in [DIV_STEPS];
   mag_type      ap_ff  [DIV_STEPS], ap_in  [DIV_STEPS];
   logic         sat_ff [DIV_STEPS], sat_in [DIV_STEPS];
   lane_tag_type tag_ff [DIV_STEPS], tag_in [DIV_STEPS];
   logic         aq0_ff, aq0_in;

   always_comb begin
      logic [CW:0] sh;
      mag_type     prem;
      quo_type     pquo;
      mag_type     pap;
      logic        nbit;
      logic        ge;
      aq0_in = aq[0];
      for (int k = 0; k < DIV_STEPS; k++) begin
         if (k == 0) begin
            prem      = {2'b00, aq[CW-1:2]};
            pquo      = '0;
            pap       = ap;
            nbit      = aq[1];
            sat_in[k] = sat;
            tag_in[k] = tag;
         end else begin
            prem      = rem_ff[k-1];
            pquo      = quo_ff[k-1];
            pap       = ap_ff[k-1];
            nbit      = (k == 1) ? aq0_ff : 1'b0;
            sat_in[k] = sat_ff[k-1];
            tag_in[k] = tag_ff[k-1];
         end
         sh        = {prem, nbit};
         ge        = sh >= {1'b0, pap};
         rem_in[k] = ge ? mag_type'(sh - {1'b0, pap}) : sh[CW-1:0];
         quo_in[k] = {pquo[QW-2:0], ge};
         ap_in[k]  = pap;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         ap_ff  <= ap_in;
         sat_ff <= sat_in;
         tag_ff <= tag_in;
         aq0_ff <= aq0_in;
      end
   end

   assign quo     = sat_ff[DIV_STEPS-1] ? Q_SAT : quo_ff[DIV_STEPS-1];
   assign tag_out = tag_ff[DIV_STEPS-1];

endmodule

// ===== sv/lcp_lerp.sv =====
// Entry/exit selection stage and endpoint product stage.
// Depends on lcp_pkg.
module lcp_lerp (
   input  logic                  clock,
   input  logic                  en,
   input  lcp_pkg::quo_type      quo [lcp_pkg::LANES],
   input  lcp_pkg::lane_tag_type tag [lcp_pkg::LANES],
   input  lcp_pkg::seg_type      seg,
   output lcp_pkg::mag_type      prod [lcp_pkg::NCOORD],
   output logic                  vis,
   output lcp_pkg::seg_type      seg_out
);
   import lcp_pkg::*;

   param_type t_in_ff, t_in_in, t_out_ff, t_out_in;
   logic      vsel_ff, vsel_in;
   seg_type   sseg_ff;
   mag_type   prod_ff [NCOORD], prod_in [NCOORD];
   logic      vmul_ff;
   seg_type   mseg_ff;

   always_comb begin
      ratio_type r;
      ratio_type ti;
      ratio_type to;
      logic      v;
      ti = '0;
      to = T_ONE;
      v  = 1'b1;
      for (int i = 0; i < LANES; i++) begin
         r = signed'({1'b0, quo[i]});
         if (tag[i].neg)
            r = -r;
         if (tag[i].pzero) begin
            if (tag[i].qneg)
               v = 1'b0;
         end else if (tag[i].pneg) begin
            if (r > ti)
               ti = r;
         end else if (r < to) begin
            to = r;
         end
      end
      if (ti > to)
         v = 1'b0;
      vsel_in  = v;
      t_in_in  = ti[FW:0];
      t_out_in = to[FW:0];
   end

   always_comb begin
      mag_type            a;
      param_type          t;
      logic [CW+FW-1:0]   full;
      for (int c = 0; c < NCOORD; c++) begin
         a = (c % 2 == 0) ? (sseg_ff.dx[CW] ? mag_type'(-sseg_ff.dx) : mag_type'(sseg_ff.dx))
                          : (sseg_ff.dy[CW] ? mag_type'(-sseg_ff.dy) : mag_type'(sseg_ff.dy));
         t = (c < 2) ? t_in_ff : t_out_ff;
         full = (CW+FW)'(a) * (CW+FW)'(t[FW-1:0]);
         prod_in[c] = t[FW] ? a : full[CW+FW-1:FW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t_in_ff  <= t_in_in;
         t_out_ff <= t_out_in;
         vsel_ff  <= vsel_in;
         sseg_ff  <= seg;
         prod_ff  <= prod_in;
         vmul_ff  <= vsel_ff;
         mseg_ff  <= sseg_ff;
      end
   end

   assign prod    = prod_ff;
   assign vis     = vmul_ff;
   assign seg_out = mseg_ff;

endmodule

// ===== sv/line_clip_parametric_core.sv =====
// Parametric line clipper against a window held in four registers.
// Top level; depends on lcp_pkg, lcp_setup, lcp_div and lcp_lerp.
//
// Use: a segment enters on the req_ stream as one transfer and leaves on
// the rsp_ stream as one transfer: the clipped endpoints in rsp_tdata and
// the visible flag in rsp_tuser. An invisible segment gives zero endpoints.
// The window is written through the csr_ port (left, bottom, right, top,
// indexes 0 to 3) while no segment is in flight.
// Pipeline: an accepted request passes the setup register, the
// one-bit-per-stage dividers (18 stages) and the selection, multiply and
// output registers to a valid response. Every stage holds its own valid bit.
// Throughput: one segment per cycle while the pipeline is not stalled.
// Stall: when rsp_tready is low while a response waits, the whole pipeline
// holds and req_tready drops; nothing is lost or repeated.
// Reset: valid bits clear and the window returns to (0, 0) - (639, 479).
module line_clip_parametric_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // start_x, start_y, end_x, end_y
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,  // clip_start_x, clip_start_y, clip_end_x, clip_end_y
   output logic        rsp_tuser,  // visible
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import lcp_pkg::*;

   coord_type    win_ff [4];
   logic         en;
   logic         vset_ff;
   logic         vdiv_ff [DIV_STEPS];
   logic         vsel_ff, vmul_ff;
   logic         rsp_tvalid_ff;
   logic [63:0]  rsp_tdata_ff, rsp_tdata_in;
   logic         rsp_tuser_ff;
   seg_type      dseg_ff [DIV_STEPS];
   seg_type      seg0, lseg;
   mag_type      aq [LANES], ap [LANES];
   logic         sat [LANES];
   lane_tag_type tag [LANES], qtag [LANES];
   quo_type      quo [LANES];
   mag_type      prod [NCOORD];
   logic         vis;

   assign en         = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff[REG_WIN_LEFT]   <= 16'sd0;
         win_ff[REG_WIN_BOTTOM] <= 16'sd0;
         win_ff[REG_WIN_RIGHT]  <= 16'sd639;
         win_ff[REG_WIN_TOP]    <= 16'sd479;
      end else if (csr_we) begin
         win_ff[csr_index] <= coord_type'(csr_wdata);
      end
   end

   lcp_setup u_setup (
      .clock      (clock),
      .en         (en),
      .start_x    (coord_type'(req_tdata[15:0])),
      .start_y    (coord_type'(req_tdata[31:16])),
      .end_x      (coord_type'(req_tdata[47:32])),
      .end_y      (coord_type'(req_tdata[63:48])),
      .win_left   (win_ff[REG_WIN_LEFT]),
      .win_bottom (win_ff[REG_WIN_BOTTOM]),
      .win_right  (win_ff[REG_WIN_RIGHT]),
      .win_top    (win_ff[REG_WIN_TOP]),
      .aq         (aq),
      .ap         (ap),
      .sat        (sat),
      .tag        (tag),
      .seg        (seg0)
   );

   for (genvar i = 0; i < LANES; i++) begin : g_div
      lcp_div u_div (
         .clock   (clock),
         .en      (en),
         .aq      (aq[i]),
         .ap      (ap[i]),
         .sat     (sat[i]),
         .tag     (tag[i]),
         .quo     (quo[i]),
         .tag_out (qtag[i])
      );
   end

   lcp_lerp u_lerp (
      .clock   (clock),
      .en      (en),
      .quo     (quo),
      .tag     (qtag),
      .seg     (dseg_ff[DIV_STEPS-1]),
      .prod    (prod),
      .vis     (vis),
      .seg_out (lseg)
   );

   always_comb begin
      coord_type s;
      logic      neg;
      for (int c = 0; c < NCOORD; c++) begin
         s   = (c % 2 == 0) ? lseg.x0 : lseg.y0;
         neg = (c % 2 == 0) ? lseg.dx[CW] : lseg.dy[CW];
         rsp_tdata_in[c*16 +: 16] = vis ? (neg ? s - prod[c] : s + prod[c]) : 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dseg_ff[0] <= seg0;
         for (int k = 1; k < DIV_STEPS; k++)
            dseg_ff[k] <= dseg_ff[k-1];
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tuser_ff <= vis;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vset_ff       <= 1'b0;
         vdiv_ff       <= '{default: 1'b0};
         vsel_ff       <= 1'b0;
         vmul_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         vset_ff    <= req_tvalid;
         vdiv_ff[0] <= vset_ff;
         for (int k = 1; k < DIV_STEPS; k++)
            vdiv_ff[k] <= vdiv_ff[k-1];
         vsel_ff       <= vdiv_ff[DIV_STEPS-1];
         vmul_ff       <= vsel_ff;
         rsp_tvalid_ff <= vmul_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule
